// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared widths, register map and helpers for the KMP pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Pattern store and counters
    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);      // pattern / table index
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);  // matched count, length
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 32;
    localparam int START_W     = 32;
    localparam int PAT_BITS    = MAX_PATTERN * BYTE_W;

    // APB register file: 64-bit registers at 8-byte spacing
    localparam int APB_DW      = 64;
    localparam int REG_IDX_W   = 3;
    localparam int APB_AW      = REG_IDX_W + 3;
    localparam int PAT_REG_W   = 2;                        // selects one pattern word

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_0  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_1  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT_2  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAT_3  = 3'd4;

    // Clamp the programmed length into 1..MAX_PATTERN
    function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = CNT_W'(1);
        end else if (len > CNT_W'(MAX_PATTERN)) begin
            res = CNT_W'(MAX_PATTERN);
        end
        return res;
    endfunction

endpackage

// ===== rtl/kmp_if.sv =====
// ----------------------------------------------------------------------------
// kmp_if
// Valid/ready channels of the KMP matcher: text input and match result.
// ----------------------------------------------------------------------------
interface kmp_in_if;
    import kmp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface kmp_out_if;
    import kmp_pkg::*;

    logic               valid;
    logic               ready;
    logic               match_found;
    logic [START_W-1:0] match_start;

    modport source (output valid, match_found, match_start, input ready);
    modport sink   (input valid, match_found, match_start, output ready);
endinterface

// ===== rtl/kmp_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// kmp_pattern_matcher
// Knuth-Morris-Pratt byte-stream matcher with an APB-programmed pattern.
// ----------------------------------------------------------------------------
// One text byte is taken per item and one result item comes back for each.
// A byte that needs no fallback goes from S_IDLE to S_CMP; each fallback
// step through the failure table adds S_FWAIT for one read of the failure
// RAM (registered read port), and a full match adds S_MWAIT to read the
// entry for the last pattern byte. A finished result sits in an output
// register, so the next byte is taken while the result waits. After reset
// and after any write to the length or pattern registers, the failure table
// is rebuilt into its RAM before new bytes are taken: S_BINIT alone for a
// one-byte pattern, else S_BLOAD and S_BCMP per further byte plus S_BWAIT
// per fallback. A write also clears the matched count; the position is
// kept. match_start is the first byte's position, 0 when no match.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kmp_in_if.sink                         i_text,
    kmp_out_if.source                      o_match,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kmp_pkg::APB_AW-1:0]     paddr,
    input  logic [kmp_pkg::APB_DW-1:0]     pwdata,
    output logic [kmp_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import kmp_pkg::*;

    typedef enum logic [3:0] {
        S_BINIT,   // clear table entry 0, start the rebuild
        S_BLOAD,   // latch pattern byte i
        S_BCMP,    // compare byte i against byte k
        S_BWAIT,   // k falls back through the table
        S_IDLE,    // wait for a text byte
        S_CMP,     // compare text byte against pattern byte j
        S_FWAIT,   // j falls back through the table
        S_MWAIT,   // full match: j takes the entry of the last byte
        S_HOLD     // result waits for the output register
    } t_state;

    t_state              r_state;

    // Configuration registers
    logic [CNT_W-1:0]    r_len;
    logic [PAT_BITS-1:0] r_pat;

    // Matcher state
    logic [CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]    r_pos;
    logic [BYTE_W-1:0]   r_char;
    logic                r_last;
    logic                r_found;
    logic [START_W-1:0]  r_start;

    // Table rebuild state
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_k;
    logic [BYTE_W-1:0]   r_pc;

    // Output register
    logic                r_ovalid;
    logic                r_ofound;
    logic [START_W-1:0]  r_ostart;

    logic [CNT_W-1:0]    w_len;
    logic [IDX_W-1:0]    w_pat_addr;
    logic [BYTE_W-1:0]   w_pat_byte;
    logic                w_eq_txt;
    logic                w_eq_bld;
    logic [CNT_W-1:0]    w_jn;
    logic [IDX_W-1:0]    w_kn;
    logic                w_slot;
    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_cfg_hit;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic [PAT_REG_W-1:0] w_pat_sel;
    logic [POS_W-1:0]    w_pos_inc;
    logic [START_W-1:0]  w_start;
    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    logic [CNT_W-1:0]    w_ram_wdata;
    logic [IDX_W-1:0]    w_ram_raddr;
    logic [CNT_W-1:0]    w_ram_rdata;

    // Failure table. Build writes entry i and later reads only entries below k <= i,
    // each written in an earlier S_BCMP with S_BLOAD in between: no forwarding needed.
    kmp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // APB decode
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_AW-1:3];
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_hit = w_cfg_wr && (w_reg_idx <= REG_PAT_3);
    assign w_pat_sel = PAT_REG_W'(w_reg_idx - REG_PAT_0);

    // Register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_LENGTH: prdata = APB_DW'(r_len);
            REG_PAT_0:  prdata = r_pat[0*APB_DW +: APB_DW];
            REG_PAT_1:  prdata = r_pat[1*APB_DW +: APB_DW];
            REG_PAT_2:  prdata = r_pat[2*APB_DW +: APB_DW];
            REG_PAT_3:  prdata = r_pat[3*APB_DW +: APB_DW];
            default:    prdata = '0;
        endcase
    end

    // Single pattern read port, address picked by state
    always_comb begin
        unique case (r_state)
            S_BLOAD: w_pat_addr = r_i;
            S_BCMP:  w_pat_addr = r_k;
            default: w_pat_addr = r_cnt[IDX_W-1:0];
        endcase
    end
    assign w_pat_byte = r_pat[w_pat_addr*BYTE_W +: BYTE_W];

    assign w_len     = eff_len(r_len);
    assign w_eq_txt  = (w_pat_byte == r_char);
    assign w_eq_bld  = (w_pat_byte == r_pc);
    assign w_jn      = r_cnt + CNT_W'(w_eq_txt);
    assign w_kn      = r_k + IDX_W'(w_eq_bld);
    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_start   = START_W'(r_pos - POS_W'(w_len) + POS_W'(1));

    assign w_slot    = !r_ovalid || o_match.ready;
    assign i_text.ready = (r_state == S_IDLE);
    assign w_accept  = i_text.valid && (r_state == S_IDLE);

    // Failure RAM ports
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_i;
        w_ram_wdata = CNT_W'(w_kn);
        w_ram_raddr = r_cnt[IDX_W-1:0] - IDX_W'(1);
        unique case (r_state)
            S_BINIT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = '0;
                w_ram_wdata = '0;
            end
            S_BCMP: begin
                w_ram_raddr = r_k - IDX_W'(1);
                w_ram_we    = !((r_k != '0) && !w_eq_bld);
            end
            S_CMP: begin
                if ((r_cnt == '0) || w_eq_txt) begin
                    w_ram_raddr = IDX_W'(w_len - CNT_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    // State machine, matcher state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BINIT;
            r_len    <= CNT_W'(1);
            r_pat    <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output register drains
            if (o_match.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_BINIT: begin
                    r_i <= IDX_W'(1);
                    r_k <= '0;
                    r_state <= (w_len == CNT_W'(1)) ? S_IDLE : S_BLOAD;
                end
                S_BLOAD: begin
                    r_pc    <= w_pat_byte;
                    r_state <= S_BCMP;
                end
                S_BCMP: begin
                    if ((r_k != '0) && !w_eq_bld) begin
                        r_state <= S_BWAIT;
                    end else begin
                        r_k <= w_kn;
                        if (CNT_W'(r_i) + CNT_W'(1) == w_len) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_BLOAD;
                        end
                    end
                end
                S_BWAIT: begin
                    r_k     <= w_ram_rdata[IDX_W-1:0];
                    r_state <= S_BCMP;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_char  <= i_text.text_byte;
                        r_last  <= i_text.end_of_text;
                        if (r_cnt >= w_len) begin
                            r_cnt <= '0;
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if ((r_cnt != '0) && !w_eq_txt) begin
                        r_state <= S_FWAIT;
                    end else if (w_jn == w_len) begin
                        r_found <= 1'b1;
                        r_start <= w_start;
                        r_state <= S_MWAIT;
                    end else begin
                        // no full match: finish here
                        r_cnt   <= r_last ? '0 : w_jn;
                        r_pos   <= r_last ? '0 : w_pos_inc;
                        r_found <= 1'b0;
                        r_start <= '0;
                        if (w_slot) begin
                            r_ovalid <= 1'b1;
                            r_ofound <= 1'b0;
                            r_ostart <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state  <= S_HOLD;
                        end
                    end
                end
                S_FWAIT: begin
                    r_cnt   <= w_ram_rdata;
                    r_state <= S_CMP;
                end
                S_MWAIT: begin
                    r_cnt <= r_last ? '0 : w_ram_rdata;
                    r_pos <= r_last ? '0 : w_pos_inc;
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_found;
                        r_ostart <= r_start;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state  <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_found;
                        r_ostart <= r_start;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_BINIT;
                end
            endcase

            // register write: store, clear the count, rebuild the table
            if (w_cfg_hit) begin
                if (w_reg_idx == REG_LENGTH) begin
                    r_len <= pwdata[CNT_W-1:0];
                end else begin
                    r_pat[w_pat_sel*APB_DW +: APB_DW] <= pwdata;
                end
                r_cnt   <= '0;
                r_state <= S_BINIT;
            end
        end
    end

    assign o_match.valid       = r_ovalid;
    assign o_match.match_found = r_ofound;
    assign o_match.match_start = r_ostart;

endmodule

// ===== rtl/kmp_ram.sv =====
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kmp_checker.sv =====
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks of the KMP matcher, bound to the top level.
// ----------------------------------------------------------------------------
module kmp_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_out_found,
    input  logic [kmp_pkg::START_W-1:0] i_out_start,
    input  logic                       i_cfg_wr,
    input  logic [kmp_pkg::APB_AW-1:0] i_paddr
);
    import kmp_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_found) && $stable(i_out_start))
        else $error("result changed while stalled");

    // A result without a match reports start zero
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_start == '0)
        else $error("match_start nonzero without a match");

    // One byte at a time: no item taken right after another
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // A length or pattern write starts the table rebuild, input is closed
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr && (i_paddr[APB_AW-1:3] <= REG_PAT_3) |=> !i_in_ready)
        else $error("input open during table rebuild");

endmodule

bind kmp_pattern_matcher kmp_checker u_kmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_out_valid (o_match.valid),
    .i_out_ready (o_match.ready),
    .i_out_found (o_match.match_found),
    .i_out_start (o_match.match_start),
    .i_cfg_wr    (psel & penable & pwrite & pready),
    .i_paddr     (paddr)
);

// ===== bench/kmp_pattern_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_tb
// Self-checking bench for the KMP matcher. Patterns go in over APB while the
// matcher is idle. Text bytes are sent with random gaps and the results are
// taken with random stalls. An in-bench search model predicts match_found
// and match_start for every accepted byte, and each result is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_tb;
    import kmp_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_WAIT  = 4;      // idle cycles after the last result
    localparam int FINAL_WAIT   = 150;    // covers a full table rebuild
    localparam int STALL_LIMIT  = 2000;   // cycles with no transfer at all
    localparam int PHASE_BYTES  = 75;
    localparam int NUM_PHASES   = 10;
    localparam int HOLD_CYCLES  = 300;

    // Register slots with no register behind them
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_B = 8'h42;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } t_match;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    kmp_in_if  text_if();
    kmp_out_if match_if();

    kmp_pattern_matcher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_match (match_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pending results and run status
    t_match      expected_matches[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent  = 0;
    int unsigned sink_hold   = 0;
    bit          fast_text   = 1'b0;
    bit          fast_sink   = 1'b0;

    // Search model state
    logic [CNT_W-1:0]  len_cfg;
    logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
    int unsigned       fallback [MAX_PATTERN];
    int unsigned       prefix_len;
    logic [POS_W-1:0]  text_pos;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Search model
    // ------------------------------------------------------------------------

    // Programmed length with 0 read as 1 and oversize read as the maximum
    function automatic int unsigned active_len();
        int unsigned n;
        n = 32'(len_cfg);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    // Longest proper prefix that is also a suffix, per pattern prefix
    function automatic void rebuild_fallback();
        int unsigned n;
        int unsigned k;
        n = active_len();
        k = 0;
        foreach (fallback[i]) fallback[i] = 0;
        for (int i = 1; i < n; i++) begin
            while (k > 0 && pat_mem[i] != pat_mem[k]) k = fallback[k - 1];
            if (pat_mem[i] == pat_mem[k]) k++;
            fallback[i] = k;
        end
    endfunction

    function automatic void apply_reg_write(input logic [REG_IDX_W-1:0] idx,
                                            input logic [APB_DW-1:0] value);
        bit known;
        int base;
        known = 1'b1;
        case (idx)
            REG_LENGTH: begin
                len_cfg = value[CNT_W-1:0];
            end
            REG_PAT_0, REG_PAT_1, REG_PAT_2, REG_PAT_3: begin
                base = 8 * (int'(idx) - int'(REG_PAT_0));
                for (int b = 0; b < 8; b++) pat_mem[base + b] = value[8*b +: 8];
            end
            default: known = 1'b0;
        endcase
        // writes to real registers restart the search; the position stays
        if (known) begin
            prefix_len = 0;
            rebuild_fallback();
        end
    endfunction

    // One text byte through the matcher
    function automatic t_match step_matcher(input logic [BYTE_W-1:0] c, input logic eot);
        t_match      res;
        int unsigned n;
        int unsigned j;
        n   = active_len();
        j   = prefix_len;
        res = '0;
        if (j >= n) j = 0;
        while (j > 0 && pat_mem[j] != c) j = fallback[j - 1];
        if (pat_mem[j] == c) j++;
        if (j == n) begin
            res.found = 1'b1;
            res.start = text_pos - POS_W'(n) + POS_W'(1);
            j = fallback[n - 1];
        end
        prefix_len = j;
        text_pos   = text_pos + POS_W'(1);
        if (eot) begin
            prefix_len = 0;
            text_pos   = '0;
        end
        return res;
    endfunction

    // Append one prediction behind the ones still pending
    function automatic void queue_expected(input t_match m);
        expected_matches = {expected_matches, m};
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    function automatic logic pick_end_mark();
        return ($urandom_range(0, 39) == 0);
    endfunction

    // Offer one text byte, wait for it to be taken, queue its prediction
    task automatic send_text(input logic [BYTE_W-1:0] c, input logic eot);
        int unsigned gap;
        gap = fast_text ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= c;
        text_if.end_of_text <= eot;
        do @(posedge i_clk); while (!text_if.ready);
        queue_expected(step_matcher(c, eot));
        bytes_sent++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        text_if.valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then idle with psel low
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg_write(idx, value);
        @(posedge i_clk);
    endtask

    // Length (junk in the unused upper bits) and all four pattern words
    task automatic load_pattern(input logic [CNT_W-1:0] len, input logic [PAT_BITS-1:0] pat);
        logic [APB_DW-1:0] len_word;
        len_word = {$urandom(), $urandom()};
        len_word[CNT_W-1:0] = len;
        reg_write(REG_LENGTH, len_word);
        reg_write(REG_PAT_0, pat[0*APB_DW +: APB_DW]);
        reg_write(REG_PAT_1, pat[1*APB_DW +: APB_DW]);
        reg_write(REG_PAT_2, pat[2*APB_DW +: APB_DW]);
        reg_write(REG_PAT_3, pat[3*APB_DW +: APB_DW]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset pattern is a single zero byte
    task automatic test_reset_pattern();
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);
        drain_results();
    endtask

    // Length 0 behaves as a one-byte pattern
    task automatic test_zero_length();
        load_pattern('0, PAT_BITS'(8'hFF));
        send_text(8'hFF, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(8'hFF, 1'b1);
        drain_results();
    endtask

    // "ABA" over "ABABA": two matches sharing a byte
    task automatic test_overlapping_matches();
        load_pattern(CNT_W'(3), PAT_BITS'({CHAR_A, CHAR_B, CHAR_A}));
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        send_text(CHAR_A, 1'b1);
        drain_results();
    endtask

    // A register write mid-text drops the partial match, keeps the position
    task automatic test_write_clears_prefix();
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        drain_results();
        reg_write(REG_LENGTH, APB_DW'(3));
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        send_text(CHAR_A, 1'b1);
        drain_results();
    endtask

    // Writes to empty register slots leave the partial match alone
    task automatic test_unused_registers();
        send_text(CHAR_A, 1'b0);
        send_text(CHAR_B, 1'b0);
        drain_results();
        reg_write(REG_UNUSED_LO, {$urandom(), $urandom()});
        reg_write(REG_UNUSED_HI, {$urandom(), $urandom()});
        send_text(CHAR_A, 1'b1);
        drain_results();
    endtask

    // Random patterns over small alphabets, text built mostly from copies
    task automatic test_random_texts();
        logic [PAT_BITS-1:0]  pat;
        logic [BYTE_W-1:0]    alphabet [4];
        logic [CNT_W-1:0]     len;
        logic [REG_IDX_W-1:0] junk_idx;
        int unsigned          n;
        int unsigned          n_sym;
        int unsigned          cut;
        int unsigned          stop;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       len = CNT_W'(1);
                1:       len = CNT_W'(MAX_PATTERN);
                2:       len = '1;                        // largest value, clamped
                3:       len = '0;
                4:       len = CNT_W'($urandom_range(MAX_PATTERN + 1, 62));
                default: len = CNT_W'($urandom_range(2, 12));
            endcase
            n_sym = $urandom_range(1, 4);
            foreach (alphabet[i]) alphabet[i] = BYTE_W'($urandom());
            for (int i = 0; i < MAX_PATTERN; i++) begin
                pat[8*i +: 8] = alphabet[$urandom_range(0, n_sym - 1)];
            end
            load_pattern(len, pat);
            if ($urandom_range(0, 2) == 0) begin
                junk_idx = REG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
                reg_write(junk_idx, {$urandom(), $urandom()});
            end
            n = active_len();

            // phase 1 runs with no idling on either side
            fast_text = (p == 1) || ($urandom_range(0, 4) == 0);
            fast_sink = (p == 1) || ($urandom_range(0, 4) == 0);

            stop = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // whole copy, or a prefix broken off by another byte
                        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
                        for (int k = 0; k < cut; k++) send_text(pat[8*k +: 8], pick_end_mark());
                        if (cut < n) begin
                            send_text(alphabet[$urandom_range(0, n_sym - 1)], pick_end_mark());
                        end
                    end
                    5, 6, 7: send_text(alphabet[$urandom_range(0, n_sym - 1)], pick_end_mark());
                    default: send_text(BYTE_W'($urandom()), pick_end_mark());
                endcase
            end
            drain_results();
            fast_text = 1'b0;
            fast_sink = 1'b0;
        end
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        int unsigned n;
        n         = active_len();
        fast_text = 1'b1;
        sink_hold = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) send_text(pat_mem[i % n], 1'b0);
        drain_results();
        fast_text = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        match_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (match_if.valid && match_if.ready) begin
                stall = fast_sink ? 0 : $urandom_range(0, 5);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                match_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                match_if.ready <= 1'b0;
            end else begin
                match_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_match want;
        if (i_rst_n && match_if.valid && match_if.ready) begin
            if (expected_matches.size() == 0) begin
                $error("match_found: no item expected, got %0b start %0d",
                       match_if.match_found, match_if.match_start);
                error_count++;
            end else begin
                want = expected_matches.pop_front();
                if (match_if.match_found !== want.found) begin
                    $error("match_found: expected %0b, got %0b", want.found,
                           match_if.match_found);
                    error_count++;
                end
                if (match_if.match_start !== want.start) begin
                    $error("match_start: expected %0d, got %0d", want.start,
                           match_if.match_start);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on any port
    always @(posedge i_clk) begin
        if ((text_if.valid && text_if.ready) || (match_if.valid && match_if.ready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        text_if.valid       <= 1'b0;
        text_if.text_byte   <= '0;
        text_if.end_of_text <= 1'b0;

        // model matches the reset state: one zero byte
        len_cfg = CNT_W'(1);
        foreach (pat_mem[i]) pat_mem[i] = '0;
        prefix_len = 0;
        text_pos   = '0;
        rebuild_fallback();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pattern();
        test_zero_length();
        test_overlapping_matches();
        test_write_clears_prefix();
        test_unused_registers();
        test_random_texts();
        test_output_backpressure();

        drain_results();
        repeat (FINAL_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
